/* rtl/core/sspd_pkg.sv */
// ----------------------------------------------------------------------------
// sspd_pkg
// shared types and constants of the smoothed slope peak detector
// ----------------------------------------------------------------------------
`default_nettype none

package sspd_pkg;

    // window length default for the top level parameter
    localparam int WINDOW_DEF = 35;

    // fixed point: light reading with 8 fractional bits
    localparam int FRAC_W    = 8;
    localparam int LIGHT_W   = 10;
    localparam int VALUE_W   = LIGHT_W + FRAC_W;
    localparam logic [VALUE_W-1:0] VALUE_MAX = VALUE_W'(1023 * 256);
    localparam int TIME_W    = 32;
    localparam int MS_PER_S  = 1000;

    // shared divider: dividend fits |diff| * 1000 < 2^28, divisor is a time step
    localparam int DIV_N = 28;
    localparam int DIV_D = 32;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_THR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DLY  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REC_LIMIT  = 2'd2;
    localparam logic [9:0]  VALVE_THR_RST = 10'd1015;
    localparam logic [15:0] START_DLY_RST = 16'd2000;
    localparam logic [19:0] REC_LIMIT_RST = 20'd45000;

    typedef enum logic [1:0] {
        PH_PRIME = 2'd0,
        PH_WAIT  = 2'd1,
        PH_REC   = 2'd2,
        PH_DONE  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MEAN,
        S_UPDATE,
        S_MULT,
        S_SLOPE,
        S_FINISH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [9:0]  light_sample;
        logic [9:0]  valve_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         phase;
        logic [31:0]        elapsed_ms;
        logic signed [31:0] slope;
        logic [30:0]        peak_slope;
        logic [31:0]        peak_time_ms;
        logic               car_started;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* rtl/core/sspd_chan.sv */
// ----------------------------------------------------------------------------
// sspd_chan
// valid/ready channel carrying one word of payload type T
// ----------------------------------------------------------------------------
`default_nettype none

interface sspd_chan #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/sspd_ram.sv */
// ----------------------------------------------------------------------------
// sspd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module sspd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

/* rtl/core/sspd_div.sv */
// ----------------------------------------------------------------------------
// sspd_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module sspd_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sspd_pkg::t_div_req i_req,
    output sspd_pkg::t_div_rsp      o_rsp
);
    import sspd_pkg::*;

    localparam int CNT_W = $clog2(DIV_N);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_D-1:0] r_rem;
    logic [DIV_D-1:0] r_div;
    logic [DIV_N-1:0] r_q;

    logic [DIV_D:0]   rem_sh;
    logic [DIV_D:0]   rem_sub;
    logic             ge;

    always_comb begin
        rem_sh  = {r_rem, r_q[DIV_N-1]};
        rem_sub = rem_sh - {1'b0, r_div};
        ge      = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DIV_D-1:0] : rem_sh[DIV_D-1:0];
            r_q   <= {r_q[DIV_N-2:0], ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
endmodule

`default_nettype wire

/* rtl/core/smoothed_slope_peak_detector_unit.sv */
// ----------------------------------------------------------------------------
// smoothed_slope_peak_detector_unit
// moving average of light samples, window slope in counts per second and
// peak absolute slope tracking after a valve opening
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  i_in      in   valid/ready        time_ms, light_sample, valve_level
//  o_out     out  valid/ready        phase, elapsed_ms, slope, peak_slope,
//                                    peak_time_ms, car_started
//  i_cfg_*   in   write enable only  valve_threshold, start_delay_ms,
//                                    record_limit_ms
//
//  one input word gives exactly one output word
//  a recording word holds the sequencer from accept to next accept for two
//  passes of the shared divider (moving average update, then slope) plus the
//  sequencer steps; the slope pass is skipped on a zero time step
//  other priming, waiting and done words only pass dispatch and emit, the
//  last priming word also runs the mean division
//  i_in.ready is high only while the sequencer is idle; the output register
//  holds a finished word while the next input word is taken, and the emit
//  step waits while that register is full and not taken
//  synchronous active low reset clears all control state; ring ram has no
//  reset and is filled completely while priming before any read
// ----------------------------------------------------------------------------
`default_nettype none

module smoothed_slope_peak_detector_unit #(
    parameter int WINDOW = sspd_pkg::WINDOW_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sspd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sspd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sspd_chan.sink                               i_in,
    sspd_chan.source                             o_out
);
    import sspd_pkg::*;

    localparam int AW     = $clog2(WINDOW);
    localparam int SUM_W  = $clog2(WINDOW * 1023 + 1);
    localparam int HALF_W = WINDOW / 2;
    localparam int RAM_W  = VALUE_W + TIME_W;

    // configuration registers
    logic [9:0]  r_valve_thr;
    logic [15:0] r_start_dly;
    logic [19:0] r_rec_limit;

    // sequencer and block state
    t_state           r_state, n_state;
    t_phase           r_phase;
    logic [AW-1:0]    r_prime;
    logic [AW-1:0]    r_ptr;
    logic [SUM_W-1:0] r_sum;
    logic [VALUE_W-1:0] r_value;
    logic             r_pending;
    logic [31:0]      r_stamp;
    logic             r_started;
    logic [30:0]      r_best;
    logic [31:0]      r_best_t;

    // latched input word
    logic [31:0]      r_t;
    logic [9:0]       r_light;
    logic [9:0]       r_valve;

    // per word working registers
    logic             r_upd_neg;
    logic             r_diff_neg;
    logic [VALUE_W-1:0] r_diff_mag;
    logic [31:0]      r_dt;
    logic [DIV_N-1:0] r_slope_mag;

    // pending result fields
    t_phase           r_res_phase;
    logic [31:0]      r_res_elapsed;
    logic signed [31:0] r_res_slope;

    // output register
    logic             r_out_valid;
    t_out_item        r_out;

    // shared divider
    t_div_req div_req;
    t_div_rsp div_rsp;

    sspd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ring of smoothed values and their times, read always at the ring pointer
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [RAM_W-1:0] ram_wdata;
    logic [RAM_W-1:0] ram_rdata;

    sspd_ram #(
        .WIDTH (RAM_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- datapath
    logic [VALUE_W-1:0] ring_v;
    logic [31:0]        ring_t;
    logic [VALUE_W-1:0] sample_fx;
    logic [SUM_W-1:0]   sum_next;
    logic               prime_last;
    logic               valve_hi;
    logic               take_sample;
    logic signed [VALUE_W:0] upd_n;
    logic [VALUE_W-1:0] upd_mag;
    logic signed [VALUE_W+1:0] v_raw;
    logic [VALUE_W-1:0] v_clamp;
    logic signed [VALUE_W:0] diff;
    logic [VALUE_W-1:0] mean_clamp;
    logic [31:0]        elapsed_fin;
    logic               limit_hit;
    logic               started_next;
    logic [30:0]        mag31;
    logic signed [31:0] slope_fin;

    always_comb begin
        ring_v      = ram_rdata[RAM_W-1:TIME_W];
        ring_t      = ram_rdata[TIME_W-1:0];
        sample_fx   = {r_light, {FRAC_W{1'b0}}};
        sum_next    = r_sum + SUM_W'(r_light);
        prime_last  = (r_prime == AW'(WINDOW - 1));
        valve_hi    = (r_valve >= r_valve_thr);
        // second successive open reading, or already recording
        take_sample = (r_phase == PH_REC) || ((r_phase == PH_WAIT) && valve_hi && r_pending);

        // moving average step: (sample - oldest) / window, rounded half away
        upd_n   = $signed({1'b0, sample_fx}) - $signed({1'b0, ring_v});
        upd_mag = upd_n[VALUE_W] ? VALUE_W'(-upd_n) : VALUE_W'(upd_n);

        v_raw = r_upd_neg
              ? $signed({2'b00, r_value}) - $signed({2'b00, div_rsp.quotient[VALUE_W-1:0]})
              : $signed({2'b00, r_value}) + $signed({2'b00, div_rsp.quotient[VALUE_W-1:0]});
        priority if (v_raw < 0) begin
            v_clamp = '0;
        end else if (v_raw > $signed({2'b00, VALUE_MAX})) begin
            v_clamp = VALUE_MAX;
        end else begin
            v_clamp = v_raw[VALUE_W-1:0];
        end
        diff = $signed({1'b0, v_clamp}) - $signed({1'b0, ring_v});

        mean_clamp = (div_rsp.quotient > DIV_N'(VALUE_MAX))
                   ? VALUE_MAX : div_rsp.quotient[VALUE_W-1:0];

        elapsed_fin  = r_t - r_stamp;
        limit_hit    = (elapsed_fin >= 32'(r_rec_limit));
        started_next = r_started || (elapsed_fin >= 32'(r_start_dly));
        mag31        = 31'(r_slope_mag);
        slope_fin    = r_diff_neg ? -$signed(32'(r_slope_mag)) : $signed(32'(r_slope_mag));
    end

    // ------------------------------------------------------------ next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in.valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (r_phase)
                    PH_PRIME: n_state = prime_last ? S_MEAN : S_EMIT;
                    PH_WAIT:  n_state = take_sample ? S_UPDATE : S_EMIT;
                    PH_REC:   n_state = S_UPDATE;
                    PH_DONE:  n_state = S_EMIT;
                endcase
            end
            S_MEAN:     if (div_rsp.done) n_state = S_EMIT;
            S_UPDATE:   if (div_rsp.done) n_state = S_MULT;
            S_MULT:     n_state = (r_dt == '0) ? S_FINISH : S_SLOPE;
            S_SLOPE:    if (div_rsp.done) n_state = S_FINISH;
            S_FINISH:   n_state = S_EMIT;
            S_EMIT:     if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // --------------------------------------------------------------- outputs
    always_comb begin
        i_in.ready       = (r_state == S_IDLE);
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = DIV_D'(WINDOW);
        ram_we           = 1'b0;
        ram_waddr        = r_ptr;
        ram_wdata        = {r_value, r_t};
        unique case (r_state)
            S_DISPATCH: begin
                if (r_phase == PH_PRIME) begin
                    // raw sample into the ring while priming
                    ram_we    = 1'b1;
                    ram_waddr = r_prime;
                    ram_wdata = {sample_fx, r_t};
                    if (prime_last) begin
                        // mean = (sum * 256 + window / 2) / window
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_N'({sum_next, {FRAC_W{1'b0}}}) + DIV_N'(HALF_W);
                    end
                end else if (take_sample) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'(upd_mag) + DIV_N'(HALF_W);
                end
            end
            S_MULT: begin
                // slope = diff * 1000 / dt, skipped on a zero time step
                if (r_dt != '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_N'(r_diff_mag) * DIV_N'(MS_PER_S);
                    div_req.divisor  = r_dt;
                end
            end
            S_FINISH: begin
                ram_we = 1'b1;
            end
            S_IDLE, S_MEAN, S_UPDATE, S_SLOPE, S_EMIT: begin
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve_thr <= VALVE_THR_RST;
            r_start_dly <= START_DLY_RST;
            r_rec_limit <= REC_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_VALVE_THR: r_valve_thr <= i_cfg_data[9:0];
                CFG_START_DLY: r_start_dly <= i_cfg_data[15:0];
                CFG_REC_LIMIT: r_rec_limit <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_PRIME;
            r_prime     <= '0;
            r_ptr       <= '0;
            r_sum       <= '0;
            r_value     <= '0;
            r_pending   <= 1'b0;
            r_stamp     <= '0;
            r_started   <= 1'b0;
            r_best      <= '0;
            r_best_t    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register: load a finished word, else drop a taken one
            priority if ((r_state == S_EMIT) && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_DISPATCH: begin
                    unique case (r_phase)
                        PH_PRIME: begin
                            r_sum <= sum_next;
                            if (!prime_last) begin
                                r_prime <= r_prime + 1'b1;
                            end
                        end
                        PH_WAIT: begin
                            priority if (!valve_hi) begin
                                r_pending <= 1'b0;
                            end else if (!r_pending) begin
                                r_pending <= 1'b1;
                            end else begin
                                // valve open: this sample is recorded at once
                                r_pending <= 1'b0;
                                r_stamp   <= r_t;
                                r_phase   <= PH_REC;
                            end
                        end
                        PH_REC, PH_DONE: begin
                        end
                    endcase
                end
                S_MEAN: begin
                    if (div_rsp.done) begin
                        r_value <= mean_clamp;
                        r_prime <= '0;
                        r_ptr   <= '0;
                        r_phase <= PH_WAIT;
                    end
                end
                S_UPDATE: begin
                    if (div_rsp.done) begin
                        r_value <= v_clamp;
                    end
                end
                S_FINISH: begin
                    r_ptr <= (r_ptr == AW'(WINDOW - 1)) ? '0 : r_ptr + 1'b1;
                    if (limit_hit) begin
                        r_phase <= PH_DONE;
                    end else begin
                        r_started <= started_next;
                        if (started_next && (mag31 > r_best)) begin
                            r_best   <= mag31;
                            r_best_t <= r_t;
                        end
                    end
                end
                S_IDLE, S_MULT, S_SLOPE, S_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // payload and working registers, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_t     <= i_in.data.time_ms;
            r_light <= i_in.data.light_sample;
            r_valve <= i_in.data.valve_level;
        end

        unique case (r_state)
            S_DISPATCH: begin
                r_upd_neg     <= upd_n[VALUE_W];
                r_res_slope   <= '0;
                // frozen block still reports elapsed time
                r_res_elapsed <= (r_phase == PH_DONE) ? (r_t - r_stamp) : '0;
                unique case (r_phase)
                    PH_PRIME: r_res_phase <= PH_PRIME;
                    PH_WAIT:  r_res_phase <= PH_WAIT;
                    PH_REC:   r_res_phase <= PH_REC;
                    PH_DONE:  r_res_phase <= PH_DONE;
                endcase
            end
            S_UPDATE: begin
                if (div_rsp.done) begin
                    r_diff_neg <= diff[VALUE_W];
                    r_diff_mag <= diff[VALUE_W] ? VALUE_W'(-diff) : VALUE_W'(diff);
                    r_dt       <= r_t - ring_t;
                end
            end
            S_MULT: begin
                r_slope_mag <= '0;
            end
            S_SLOPE: begin
                if (div_rsp.done) begin
                    r_slope_mag <= div_rsp.quotient;
                end
            end
            S_FINISH: begin
                r_res_phase   <= limit_hit ? PH_DONE : PH_REC;
                r_res_elapsed <= elapsed_fin;
                r_res_slope   <= slope_fin;
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    r_out.phase        <= r_res_phase;
                    r_out.elapsed_ms   <= r_res_elapsed;
                    r_out.slope        <= r_res_slope;
                    r_out.peak_slope   <= r_best;
                    r_out.peak_time_ms <= r_best_t;
                    r_out.car_started  <= r_started;
                end
            end
            S_IDLE, S_MEAN: begin
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // ------------------------------------------------------------ assertions
    // priming words never carry a slope or elapsed time
    a_prime_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.data.phase == PH_PRIME))
        |-> (o_out.data.elapsed_ms == '0) && (o_out.data.slope == '0))
        else $error("priming word with nonzero slope or elapsed time");

    // the divider is never restarted while a division runs
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    // peak magnitude only grows outside reset
    a_peak_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_best >= $past(r_best)))
        else $error("peak slope decreased");

    // car start flag never clears outside reset
    a_start_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(r_started)) |-> r_started)
        else $error("car start flag cleared");

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// regression bench for smoothed_slope_peak_detector_unit: sample words are
// driven through the valid/ready input channel with random gaps, the report
// channel is stalled at random, and every report word is compared field by
// field against a cycle-free model of the averaging, slope and peak logic
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import sspd_pkg::*;

    localparam int WIN         = WINDOW_DEF;
    localparam int STALL_LIMIT = 3000;
    localparam int END_CYCLES  = 80;
    localparam int REC_TARGET  = 640;
    // index past the register list, must be ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam logic [19:0] LIMIT_MAX = 20'hFFFFF;

    typedef enum int {SEG_NOISE, SEG_RAMP, SEG_STEP, SEG_FROZEN} t_seg;

    // ------------------------------------------------------------------------
    // expected report words: model of the block plus the queue of words that
    // it has predicted and the DUT has not yet delivered
    // ------------------------------------------------------------------------
    class slope_scoreboard;
        logic [31:0]  thr, delay, limit;
        int unsigned  ring_val [WIN];
        logic [31:0]  ring_time [WIN];
        int           ptr, fill;
        longint       avg;
        bit           armed, started;
        logic [31:0]  open_stamp;
        t_phase       ph;
        logic [30:0]  best;
        logic [31:0]  best_t;
        t_out_item    expected_q [$];
        int           errors;
        int           words [4];
        int           peak_moves, zero_steps;

        function new();
            thr        = 32'(VALVE_THR_RST);
            delay      = 32'(START_DLY_RST);
            limit      = 32'(REC_LIMIT_RST);
            ptr        = 0;
            fill       = 0;
            avg        = 0;
            armed      = 1'b0;
            started    = 1'b0;
            open_stamp = '0;
            ph         = PH_PRIME;
            best       = '0;
            best_t     = '0;
            errors     = 0;
            words      = '{default: 0};
            peak_moves = 0;
            zero_steps = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_VALVE_THR: thr   = 32'(val[9:0]);
                CFG_START_DLY: delay = 32'(val[15:0]);
                CFG_REC_LIMIT: limit = 32'(val[19:0]);
                default: ;
            endcase
        endfunction

        function t_phase stage();
            return ph;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // one accepted sample word -> one predicted report word
        function void note_sample(t_in_item w);
            t_out_item          e;
            bit                 do_rec;
            int                 p;
            longint             n, v, diff, s;
            logic [31:0]        t, dt, el, mag;
            logic signed [31:0] sl;
            t      = w.time_ms;
            e      = '0;
            do_rec = 1'b0;
            case (ph)
                PH_PRIME: begin
                    // raw readings fill the ring, the sum turns into the mean
                    p            = fill;
                    ring_val[p]  = 32'({w.light_sample, 8'h00});
                    ring_time[p] = t;
                    avg          = avg + longint'(w.light_sample);
                    e.phase      = PH_PRIME;
                    if (p + 1 >= WIN) begin
                        avg = (avg * 256 + WIN / 2) / WIN;
                        if (avg > longint'(VALUE_MAX)) avg = longint'(VALUE_MAX);
                        ptr  = 0;
                        fill = 0;
                        ph   = PH_WAIT;
                    end else begin
                        fill = p + 1;
                    end
                end
                PH_WAIT: begin
                    e.phase = PH_WAIT;
                    if (32'(w.valve_level) < thr) begin
                        armed = 1'b0;
                    end else if (!armed) begin
                        armed = 1'b1;
                    end else begin
                        // second open reading in a row opens the valve
                        armed      = 1'b0;
                        open_stamp = t;
                        ph         = PH_REC;
                        do_rec     = 1'b1;
                    end
                end
                PH_REC: do_rec = 1'b1;
                default: begin
                    // frozen, only elapsed keeps moving
                    e.phase      = PH_DONE;
                    e.elapsed_ms = t - open_stamp;
                end
            endcase

            if (do_rec) begin
                p = ptr;
                n = longint'({w.light_sample, 8'h00}) - longint'(ring_val[p]);
                if (n >= 0) n = (n + WIN / 2) / WIN;
                else        n = -((-n + WIN / 2) / WIN);
                v = avg + n;
                if (v < 0) v = 0;
                if (v > longint'(VALUE_MAX)) v = longint'(VALUE_MAX);
                avg  = v;
                dt   = t - ring_time[p];
                diff = v - longint'(ring_val[p]);
                if (dt == 0) begin
                    sl = '0;
                    zero_steps++;
                end else begin
                    s = (diff * 1000) / longint'({32'b0, dt});
                    if (s > 64'sh7FFF_FFFF)  s = 64'sh7FFF_FFFF;
                    if (s < -64'sh8000_0000) s = -64'sh8000_0000;
                    sl = s[31:0];
                end
                ring_val[p]  = int'(v);
                ring_time[p] = t;
                ptr          = (p + 1) % WIN;
                el           = t - open_stamp;
                e.elapsed_ms = el;
                e.slope      = sl;
                if (el >= limit) begin
                    // stop word reports its slope but touches no peak state
                    ph      = PH_DONE;
                    e.phase = PH_DONE;
                end else begin
                    e.phase = PH_REC;
                    if (!started && el >= delay) started = 1'b1;
                    if (started) begin
                        if (sl < 0) mag = (sl == 32'sh8000_0000) ? 32'h7FFF_FFFF : -sl;
                        else        mag = sl;
                        if (mag > 32'h7FFF_FFFF) mag = 32'h7FFF_FFFF;
                        if (mag > {1'b0, best}) begin
                            best   = mag[30:0];
                            best_t = t;
                            peak_moves++;
                        end
                    end
                end
            end

            e.peak_slope   = best;
            e.peak_time_ms = best_t;
            e.car_started  = started;
            words[e.phase]++;
            expected_q.push_back(e);
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_word(t_out_item a);
            t_out_item e;
            if (expected_q.size() == 0) begin
                $display("%0t: report word with nothing expected, expected none, got %h",
                         $time, a);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            cmp_field("phase",        32'(e.phase),        32'(a.phase));
            cmp_field("elapsed_ms",   e.elapsed_ms,        a.elapsed_ms);
            cmp_field("slope",        e.slope,             a.slope);
            cmp_field("peak_slope",   32'(e.peak_slope),   32'(a.peak_slope));
            cmp_field("peak_time_ms", e.peak_time_ms,      a.peak_time_ms);
            cmp_field("car_started",  32'(e.car_started),  32'(a.car_started));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, configuration port and channels
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm;          // no gaps on either side while set
    logic [31:0]           now;           // timestamp of the last sample sent
    int                    idle_cycles;
    int                    cfg_writes;
    slope_scoreboard       sb;

    sspd_chan #(.T(t_in_item))  sample_ch ();
    sspd_chan #(.T(t_out_item)) report_ch ();

    smoothed_slope_peak_detector_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (sample_ch.sink),
        .o_out      (report_ch.source)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // driver tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------------

    // register write, the enable is cleared again before the task returns so that
    // back to back writes never touch the enable twice in one step
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.set_reg(idx, val);
        cfg_writes++;
        @(negedge clk);
    endtask

    // send one sample word, time advances by step (wraps, so a huge step
    // moves the clock backward)
    task automatic send_sample(input int unsigned light, input int unsigned valve,
                               input logic [31:0] step);
        t_in_item w;
        int       gap;
        gap            = calm ? 0 : $urandom_range(0, 6);
        now            = now + step;
        w.time_ms      = now;
        w.light_sample = 10'(light);
        w.valve_level  = 10'(valve);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_ch.data  <= w;
        sample_ch.valid <= 1'b1;
        do @(posedge clk); while (!sample_ch.ready);
        sb.note_sample(w);
        @(negedge clk);
    endtask

    // hold the sender until every predicted word has come back
    task automatic drain();
        sample_ch.valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    // ------------------------------------------------------------------------
    // report side: random stalls, one check per accepted word
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        report_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                report_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            report_ch.ready <= 1'b1;
            do @(posedge clk); while (!report_ch.valid);
            sb.check_word(report_ch.data);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without any word moving on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((sample_ch.valid && sample_ch.ready) ||
                     (report_ch.valid && report_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
            $display("smoothed_slope_peak_detector_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin
        int          k, len, lvl, rate, rec_sent, seg;
        bit          was_high;
        t_seg        kind;
        logic [31:0] el;

        sb              = new();
        sample_ch.valid = 1'b0;
        sample_ch.data  = '0;
        cfg_we          = 1'b0;
        cfg_idx         = '0;
        cfg_data        = '0;
        rst_n           = 1'b0;
        calm            = 1'b0;
        now             = '0;
        cfg_writes      = 0;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // threshold with bits above its width set (masks to 1023), no start
        // delay, longest record limit, and a write to an unused index
        write_reg(CFG_VALVE_THR, 20'hFFFFF);
        write_reg(CFG_START_DLY, 20'h00000);
        write_reg(CFG_REC_LIMIT, LIMIT_MAX);
        write_reg(CFG_SPARE, 20'($urandom()));

        // priming: extremes first, time starts at zero, repeats, then jumps
        // close to the top of the 32-bit range so recording wraps it
        send_sample(0, 0, 32'd0);
        send_sample(1023, 1023, 32'd0);
        send_sample(1023, 0, 32'hFFFF_F000);
        for (k = 3; k < WIN; k++)
            send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 100));

        // waiting at full threshold: single open readings get cleared, one
        // word with a backward timestamp
        send_sample($urandom_range(0, 1023), 1023, 32'd7);
        send_sample($urandom_range(0, 1023), 1022, 32'd7);
        send_sample($urandom_range(0, 1023), 1023, 32'd0);
        send_sample($urandom_range(0, 1023), 0, 32'd9);
        send_sample($urandom_range(0, 1023), 1023, -32'd5000);
        send_sample($urandom_range(0, 1023), 512, 32'd3);

        // pressure: sender stops until the pipe is empty, then new settings
        drain();
        write_reg(CFG_VALVE_THR, 20'(VALVE_THR_RST));
        write_reg(CFG_START_DLY, 20'hFFFF);

        // random waiting words, never two open readings in a row
        was_high = 1'b0;
        for (k = 0; k < 15; k++) begin
            if (!was_high && $urandom_range(0, 2) == 0) begin
                send_sample($urandom_range(0, 1023), $urandom_range(1015, 1023),
                            $urandom_range(0, 50));
                was_high = 1'b1;
            end else begin
                send_sample($urandom_range(0, 1023), $urandom_range(0, 1014),
                            $urandom_range(0, 50));
                was_high = 1'b0;
            end
        end

        // zero threshold: any reading opens, two words later recording runs
        drain();
        write_reg(CFG_VALVE_THR, 20'd0);
        while (sb.stage() == PH_WAIT)
            send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(1, 50));

        // recording: segments of noise, ramps, level steps and a stretch
        // with a stopped clock (zero time steps); settings change between
        // some segments
        rec_sent = 0;
        seg      = 0;
        while (sb.stage() == PH_REC && rec_sent < REC_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            kind = t_seg'($urandom_range(0, 3));
            if (seg == 2) kind = SEG_FROZEN;
            len  = (kind == SEG_FROZEN) ? 40 : $urandom_range(30, 60);
            lvl  = $urandom_range(0, 1023);
            rate = $urandom_range(0, 60) - 30;
            for (k = 0; k < len && sb.stage() == PH_REC; k++) begin
                case (kind)
                    SEG_NOISE:
                        send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                    $urandom_range(0, 1000));
                    SEG_RAMP: begin
                        lvl = lvl + rate;
                        if (lvl > 1023) begin lvl = 1023; rate = -rate; end
                        if (lvl < 0)    begin lvl = 0;    rate = -rate; end
                        send_sample(lvl, $urandom_range(0, 1023), $urandom_range(1, 40));
                    end
                    SEG_STEP: begin
                        if (k == len / 2) lvl = 1023 - lvl;
                        send_sample(lvl, $urandom_range(0, 1023), $urandom_range(0, 20));
                    end
                    default:
                        send_sample($urandom_range(0, 1023), $urandom_range(0, 1023), 32'd0);
                endcase
                rec_sent++;
            end
            seg++;
            if (seg % 4 == 0 && sb.stage() == PH_REC) begin
                drain();
                write_reg(CFG_VALVE_THR, 20'($urandom_range(0, 1023)));
                write_reg(CFG_START_DLY, 20'($urandom_range(0, 65535)));
                write_reg(CFG_REC_LIMIT, LIMIT_MAX - 20'($urandom_range(0, 4095)));
            end
        end
        calm = 1'b0;

        // bring the limit just ahead of the current elapsed time and let
        // the timestamps run into it
        if (sb.stage() == PH_REC) begin
            drain();
            el = now - sb.open_stamp;
            write_reg(CFG_REC_LIMIT, 20'(el + 300));
            while (sb.stage() == PH_REC)
                send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 50));
        end

        // frozen block, one backward step, then the zero limit
        for (k = 0; k < 12; k++)
            send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                        (k == 5) ? -32'd100000 : 32'($urandom_range(0, 500)));
        drain();
        write_reg(CFG_REC_LIMIT, 20'd0);
        write_reg(CFG_VALVE_THR, 20'($urandom_range(0, 1023)));
        for (k = 0; k < 6; k++)
            send_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                        $urandom_range(0, 500));

        drain();
        repeat (END_CYCLES) @(negedge clk);

        $display("covered %0d priming, %0d waiting, %0d recording and %0d frozen words",
                 sb.words[PH_PRIME], sb.words[PH_WAIT], sb.words[PH_REC],
                 sb.words[PH_DONE]);
        $display("peak moved %0d times, %0d zero time steps, %0d register writes",
                 sb.peak_moves, sb.zero_steps, cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("smoothed_slope_peak_detector_unit regression: pass");
        end else begin
            $display("smoothed_slope_peak_detector_unit regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
